// ----- hdl/zonal_statistics_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// zonal_statistics_accumulator_defines
// Assertion macros for the zonal statistics block.
// ----------------------------------------------------------------------------
`ifndef ZONAL_STATISTICS_ACCUMULATOR_DEFINES_SVH
`define ZONAL_STATISTICS_ACCUMULATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ZSA_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define ZSA_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- hdl/zsa_pkg.sv -----
// ----------------------------------------------------------------------------
// zsa_pkg
// Shared widths, operation codes and defaults for the zonal statistics block.
// ----------------------------------------------------------------------------
package zsa_pkg;
  localparam int ZONES_DEFAULT = 1024;
  localparam int CFG_W = 11;
  localparam int CNT_W = 16;
  localparam int VAL_W = 24;
  localparam int SUM_W = 40;
  localparam int SSQ_W = 64;
  localparam int VAR_W = 47;
  localparam int SD_W  = 23;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0] ZONE_COUNT_RST = 11'd1024;

  // Snapshot of a zone handed to the statistics unit.
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] s1;
    logic [SSQ_W-1:0]        s2;
  } zsa_snap_t;
endpackage

// ----- hdl/zsa_stats.sv -----
// ----------------------------------------------------------------------------
// zsa_stats
// Multi-cycle mean, population variance and square root for one zone read.
// ----------------------------------------------------------------------------
`include "zonal_statistics_accumulator_defines.svh"
module zsa_stats (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  zsa_pkg::zsa_snap_t  snap,
  output logic                done,
  output logic [23:0]         mean,
  output logic [46:0]         variance,
  output logic [22:0]         std_dev
);
  import zsa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
    S_M3 = 4'd4, S_SUB = 4'd5, S_DIV = 4'd6, S_MDIV = 4'd7, S_SQ = 4'd8,
    S_DONE = 4'd9;

  logic [3:0]   state;
  logic [6:0]   step;
  logic [15:0]  n;
  logic         neg;
  logic [39:0]  mag;
  logic [63:0]  s2;
  logic [127:0] acc;     // n*S2 then n*S2 - S1^2, later quotient
  logic [127:0] prod;    // S1^2
  logic [31:0]  d;       // n*n
  logic [32:0]  rem;
  logic [39:0]  mq;      // mean quotient / dividend
  logic [16:0]  mrem;
  logic [46:0]  var_q;
  logic [47:0]  sq_v;
  logic [47:0]  sq_r;
  logic [47:0]  sq_bit;
  logic [63:0]  pp;

  logic [32:0]  rem_sh;
  logic [16:0]  mrem_sh;
  logic [48:0]  sq_t;

  assign rem_sh  = {rem[31:0], acc[127]};
  assign mrem_sh = {mrem[15:0], mq[39]};
  assign sq_t    = {1'b0, sq_v} - {1'b0, sq_r + sq_bit};

  always_comb begin
    unique case (state)
      S_M0:    pp = 64'(s2[31:0] * n);
      S_M1:    pp = 64'(s2[63:32] * n);
      S_M2:    pp = 64'(mag[31:0] * mag[31:0]);
      S_M3:    pp = (step < 7'd2) ? 64'(mag[31:0] * {24'd0, mag[39:32]})
                                  : 64'({24'd0, mag[39:32]} * {24'd0, mag[39:32]});
      default: pp = 64'({24'd0, mag[39:32]} * {24'd0, mag[39:32]});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (go) begin
          n     <= snap.n;
          neg   <= snap.s1[SUM_W-1];
          mag   <= snap.s1[SUM_W-1] ? 40'(-snap.s1) : 40'(snap.s1);
          s2    <= snap.s2;
          acc   <= '0;
          prod  <= '0;
          d     <= 32'(snap.n * snap.n);
          state <= S_M0;
        end
        S_M0: begin acc <= 128'(pp); state <= S_M1; end
        S_M1: begin acc <= acc + {32'd0, pp, 32'd0}; state <= S_M2; end
        S_M2: begin prod <= 128'(pp); step <= 7'd0; state <= S_M3; end
        S_M3: begin
          // two cross terms, then the high square
          if (step < 7'd2) begin
            prod <= prod + {32'd0, pp, 32'd0};
            step <= step + 7'd1;
          end else begin
            prod <= prod + {pp, 64'd0};
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (prod > acc) begin
            var_q <= '0;
            state <= S_MDIV;
            mq <= mag; mrem <= '0; step <= 7'd0;
          end else begin
            acc <= acc - prod; rem <= '0; step <= 7'd0; state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if ({1'b0, rem_sh} >= {1'b0, d}) begin
            rem <= rem_sh - 33'(d);
            acc <= {acc[126:0], 1'b1};
          end else begin
            rem <= rem_sh;
            acc <= {acc[126:0], 1'b0};
          end
          step <= step + 7'd1;
          if (step == 7'd127) begin
            state <= S_MDIV; mq <= mag; mrem <= '0;
          end
        end
        S_MDIV: begin
          if (mrem_sh >= {1'b0, n}) begin
            mrem <= mrem_sh - {1'b0, n};
            mq   <= {mq[38:0], 1'b1};
          end else begin
            mrem <= mrem_sh;
            mq   <= {mq[38:0], 1'b0};
          end
          step <= step + 7'd1;
          if (step[5:0] == 6'd39) begin
            state <= S_SQ;
            step <= 7'd0;
            sq_r <= '0;
            sq_bit <= 48'h4000_0000_0000 >> 1;
          end
        end
        S_SQ: begin
          if (step == 7'd0) begin
            sq_v   <= {1'b0, var_q};
            sq_bit <= 48'h4000_0000_0000;
            step   <= 7'd1;
          end else if (sq_bit == '0) begin
            state <= S_DONE;
          end else begin
            if (!sq_t[48]) begin
              sq_v <= sq_t[47:0];
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_DONE: begin
          mean     <= neg ? 24'(-mq) : mq[23:0];
          variance <= var_q;
          std_dev  <= (sq_r > 48'h7F_FFFF) ? 23'h7F_FFFF : sq_r[22:0];
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // latch the quotient once division ends
      if (state == S_DIV && step == 7'd127)
        var_q <= (acc[126:63] != '0) ? '1 : {acc[45:0], rem_sh >= {1'b0, d}};
    end
  end

  `ZSA_ASSERT_NXT(a_done_pulse, clk, rst, done, !done, "done held")
  `ZSA_ASSERT_IMP(a_go_idle, clk, rst, go, state == S_IDLE, "go while busy")
  `ZSA_ASSERT_IMP(a_div_nz, clk, rst, state == S_DIV, d != '0, "zero divisor")
endmodule

// ----- hdl/zonal_statistics_accumulator.sv -----
// ----------------------------------------------------------------------------
// zonal_statistics_accumulator
// Per-zone count, min, max, sum and sum-of-squares table with statistics read.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Operations:
//   clear zone, add sample, read zone statistics.
//   A request holds busy until it is through: P_RD, where the zone memory
//   is written back, then P_WR; a read of a valid non-empty zone goes from
//   P_RD to P_ST instead. No new request is taken in that time.
//   Such a read additionally runs the statistics unit (multiply, 128-step
//   variance division, 40-step mean division, 24-step square root), after
//   which result_valid pulses for one cycle with all result ports set. The
//   receiver cannot stall: results must be taken.
//   Write zone_count via cfg_we/cfg_data only while idle; the block does not
//   enforce it. Reset clears control state and sets zone_count to 1024;
//   zone entries are undefined until cleared, so no clearing pass runs.
// ----------------------------------------------------------------------------
`include "zonal_statistics_accumulator_defines.svh"
module zonal_statistics_accumulator #(
  parameter int ZONES = zsa_pkg::ZONES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic signed [15:0] zone,
  input  logic signed [23:0] value,
  input  logic               no_data,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_data,
  output logic               result_valid,
  output logic [15:0]        cell_count,
  output logic signed [23:0] minimum,
  output logic signed [23:0] maximum,
  output logic [23:0]        value_range,
  output logic signed [39:0] total,
  output logic signed [23:0] mean,
  output logic [46:0]        variance,
  output logic [22:0]        std_dev,
  output logic               empty_res,
  output logic               overflowed
);
  import zsa_pkg::*;

  localparam int AW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int EW = 1 + SSQ_W + SUM_W + 2*VAL_W + CNT_W;

  localparam logic [1:0] P_IDLE = 2'd0, P_RD = 2'd1, P_WR = 2'd2, P_ST = 2'd3;

  logic [EW-1:0] mem [ZONES];
  logic [EW-1:0] rdata;
  logic [CFG_W-1:0] zone_count;
  logic [1:0] phase;
  logic [1:0] op_q;
  logic [AW-1:0] addr_q;
  logic valid_q;
  logic nd_q;
  logic signed [VAL_W-1:0] v_q;
  logic sq_go;
  zsa_snap_t snap;
  logic sq_done;
  logic [23:0] m_mean;
  logic [46:0] m_var;
  logic [22:0] m_sd;

  logic zvalid;
  assign zvalid = !zone[15] && ({5'd0, zone[14:0]} < {9'd0, zone_count}) &&
                  (32'(zone[14:0]) < ZONES);

  // unpacked fields of the stored entry
  logic               e_ov;
  logic [SSQ_W-1:0]   e_s2;
  logic signed [SUM_W-1:0] e_s1;
  logic signed [VAL_W-1:0] e_min, e_max;
  logic [CNT_W-1:0]   e_n;
  assign {e_ov, e_s2, e_s1, e_min, e_max, e_n} = rdata;

  logic [EW-1:0] wdata;
  logic signed [47:0] sqv;
  assign sqv = v_q * v_q;
  always_comb begin
    wdata = rdata;
    if (op_q == OP_CLEAR) begin
      wdata = '0;
    end else if (e_n == COUNT_MAX) begin
      wdata[EW-1] = 1'b1;
    end else begin
      wdata = {e_ov, e_s2 + 64'($unsigned(sqv)), e_s1 + SUM_W'(v_q),
               (e_n == '0 || v_q < e_min) ? v_q : e_min,
               (e_n == '0 || v_q > e_max) ? v_q : e_max, e_n + 16'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (phase == P_IDLE && start)
      rdata <= mem[zone[AW-1:0]];
    if (phase == P_RD && valid_q &&
        (op_q == OP_CLEAR || (op_q == OP_ADD && !nd_q)))
      mem[addr_q] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      zone_count <= ZONE_COUNT_RST;
      result_valid <= 1'b0;
      sq_go <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      sq_go <= 1'b0;
      if (cfg_we) zone_count <= cfg_data;
      unique case (phase)
        P_IDLE: if (start) begin
          op_q <= operation; addr_q <= zone[AW-1:0]; valid_q <= zvalid;
          nd_q <= no_data; v_q <= value; phase <= P_RD;
        end
        P_RD: begin
          if (op_q == OP_READ) begin
            cell_count <= '0; minimum <= '0; maximum <= '0;
            value_range <= '0; total <= '0; empty_res <= 1'b1;
            overflowed <= valid_q & e_ov;
            if (valid_q && e_n != '0) begin
              cell_count <= e_n; minimum <= e_min; maximum <= e_max;
              value_range <= 24'(e_max - e_min); total <= e_s1;
              empty_res <= 1'b0;
              snap <= '{n: e_n, s1: e_s1, s2: e_s2};
              sq_go <= 1'b1;
              phase <= P_ST;
            end else begin
              mean <= '0; variance <= '0; std_dev <= '0;
              result_valid <= 1'b1;
              phase <= P_WR;
            end
          end else begin
            phase <= P_WR;
          end
        end
        P_WR: phase <= P_IDLE;
        P_ST: if (sq_done) begin
          mean <= m_mean; variance <= m_var; std_dev <= m_sd;
          result_valid <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign busy = (phase != P_IDLE);

  zsa_stats u_stats (
    .clk(clk), .rst(rst), .go(sq_go), .snap(snap), .done(sq_done),
    .mean(m_mean), .variance(m_var), .std_dev(m_sd)
  );

  `ZSA_ASSERT_IMP(a_res_busy, clk, rst, result_valid, phase == P_WR || phase == P_IDLE, "result phase")
  `ZSA_ASSERT_NXT(a_acc_busy, clk, rst, start && !busy, busy, "busy after request")
  `ZSA_ASSERT_IMP(a_empty_zero, clk, rst, result_valid && empty_res, cell_count == '0, "empty count")
endmodule
